FILE: hw/rtl/hbpq_pkg.sv
// shared types, codes and constants for the binary heap priority queue
package hbpq_pkg;

  localparam int VALUE_W     = 32;
  localparam int FUNC_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 7;
  localparam int CAPACITY    = 64;

  localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_EXTRACT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEEK    = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic latch;
    logic set_full;
    logic set_empty;
    logic ins_begin;
    logic ext_begin;
    logic load_last;
    logic clear;
    logic up_place;
    logic up_step;
    logic rd_children;
    logic down_step;
    logic out_load;
  } hbpq_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              full;
    logic              empty;
    logic              last_one;
    logic              pos_zero;
    logic              up_move;
    logic              down_move;
    logic              out_free;
  } hbpq_stat_t;

endpackage

FILE: hw/rtl/hbpq_ram.sv
// generic single-write, dual-read ram with registered read data
module hbpq_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  output logic [WIDTH-1:0]  rdata_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: hw/rtl/hbpq_ctrl.sv
// controller state machine for the heap operations
module hbpq_ctrl
  import hbpq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  hbpq_stat_t stat,
  output hbpq_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_LAST_LD,
    S_UP_CHK,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_RESP
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.func)
          FUNC_INSERT: begin
            if (stat.full) begin
              cmd.set_full = 1'b1;
              state_next   = S_RESP;
            end else begin
              cmd.ins_begin = 1'b1;
              state_next    = S_UP_CHK;
            end
          end
          FUNC_EXTRACT: begin
            if (stat.empty) begin
              cmd.set_empty = 1'b1;
              state_next    = S_RESP;
            end else begin
              cmd.ext_begin = 1'b1;
              state_next    = stat.last_one ? S_RESP : S_LAST_LD;
            end
          end
          FUNC_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = S_RESP;
          end
          default: begin
            state_next = S_RESP;
          end
        endcase
      end
      S_LAST_LD: begin
        cmd.load_last = 1'b1;
        state_next    = S_DN_RD;
      end
      S_UP_CHK: begin
        if (stat.pos_zero) begin
          cmd.up_place = 1'b1;
          state_next   = S_RESP;
        end else begin
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd.up_step = 1'b1;
        state_next  = stat.up_move ? S_UP_CHK : S_RESP;
      end
      S_DN_RD: begin
        cmd.rd_children = 1'b1;
        state_next      = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd.down_step = 1'b1;
        state_next    = stat.down_move ? S_DN_RD : S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: hw/rtl/hbpq_dp.sv
// heap datapath: entry ram, count, moving value, compare and result register
module hbpq_dp
  import hbpq_pkg::*;
#(
  parameter int CAP = CAPACITY
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write_en,
  input  logic                      cfg_write_data,
  input  logic [FUNC_W-1:0]         func,
  input  logic signed [VALUE_W-1:0] value,
  input  hbpq_cmd_t                 cmd,
  output hbpq_stat_t                stat,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [STATUS_W-1:0]       status,
  output logic signed [VALUE_W-1:0] extracted_value,
  output logic [COUNT_OUT_W-1:0]    entry_count,
  output logic signed [VALUE_W-1:0] top_value,
  output logic                      top_valid
);

  localparam int AW = $clog2(CAP);
  localparam int CW = $clog2(CAP + 1);
  localparam int XW = AW + 2;

  function automatic logic better(input logic mn, input logic signed [VALUE_W-1:0] a,
                                  input logic signed [VALUE_W-1:0] b);
    return mn ? (a < b) : (a > b);
  endfunction

  logic                      min_order;
  logic [FUNC_W-1:0]         op;
  logic [CW-1:0]             count;
  logic [AW-1:0]             pos;
  logic signed [VALUE_W-1:0] cur;
  logic signed [VALUE_W-1:0] top;
  logic [STATUS_W-1:0]       res_status;
  logic signed [VALUE_W-1:0] res_extracted;

  logic                      we;
  logic [AW-1:0]             waddr;
  logic signed [VALUE_W-1:0] wdata;
  logic [AW-1:0]             raddr_a;
  logic [AW-1:0]             raddr_b;
  logic signed [VALUE_W-1:0] rdata_a;
  logic signed [VALUE_W-1:0] rdata_b;

  logic [AW-1:0]             parent;
  logic [XW-1:0]             lc;
  logic [XW-1:0]             rc;
  logic                      lc_ok;
  logic                      rc_ok;
  logic                      up_move;
  logic                      pick_l;
  logic                      pick_r;
  logic signed [VALUE_W-1:0] best_l;
  logic [CW-1:0]             last_idx;

  hbpq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAP)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  assign parent   = (pos - AW'(1)) >> 1;
  assign lc       = (XW'(pos) << 1) | XW'(1);
  assign rc       = lc + XW'(1);
  assign lc_ok    = lc < XW'(count);
  assign rc_ok    = rc < XW'(count);
  assign last_idx = count - CW'(1);

  assign up_move = better(min_order, cur, rdata_a);
  assign pick_l  = lc_ok && better(min_order, rdata_a, cur);
  assign best_l  = pick_l ? rdata_a : cur;
  assign pick_r  = rc_ok && better(min_order, rdata_b, best_l);

  // read address selection
  always_comb begin
    raddr_a = parent;
    raddr_b = rc[AW-1:0];
    if (cmd.ext_begin) begin
      raddr_a = last_idx[AW-1:0];
    end else if (cmd.rd_children) begin
      raddr_a = lc[AW-1:0];
    end
  end

  // write port
  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = cur;
    if (cmd.up_place) begin
      we = 1'b1;
    end else if (cmd.up_step) begin
      we    = 1'b1;
      wdata = up_move ? rdata_a : cur;
    end else if (cmd.down_step) begin
      we = 1'b1;
      if (pick_r) begin
        wdata = rdata_b;
      end else if (pick_l) begin
        wdata = rdata_a;
      end
    end
  end

  always_comb begin
    stat           = '0;
    stat.func      = op;
    stat.full      = (count == CW'(CAP));
    stat.empty     = (count == '0);
    stat.last_one  = (count == CW'(1));
    stat.pos_zero  = (pos == '0);
    stat.up_move   = up_move;
    stat.down_move = pick_l || pick_r;
    stat.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_order <= 1'b1;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        min_order <= cfg_write_data;
      end
      if (cmd.ins_begin) begin
        count <= count + CW'(1);
      end else if (cmd.ext_begin) begin
        count <= last_idx;
      end else if (cmd.clear) begin
        count <= '0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op            <= func;
      cur           <= value;
      res_status    <= STATUS_OK;
      res_extracted <= '0;
    end
    if (cmd.set_full) begin
      res_status <= STATUS_FULL;
    end
    if (cmd.set_empty) begin
      res_status <= STATUS_EMPTY;
    end
    if (cmd.ins_begin) begin
      pos <= count[AW-1:0];
    end
    if (cmd.ext_begin) begin
      res_extracted <= top;
    end
    if (cmd.load_last) begin
      cur <= rdata_a;
      pos <= '0;
    end
    if (cmd.up_step && up_move) begin
      pos <= parent;
    end
    if (cmd.down_step) begin
      if (pick_r) begin
        pos <= rc[AW-1:0];
      end else if (pick_l) begin
        pos <= lc[AW-1:0];
      end
    end
    // root mirror
    if (we && waddr == '0) begin
      top <= wdata;
    end
    if (cmd.out_load) begin
      status          <= res_status;
      extracted_value <= res_extracted;
      entry_count     <= COUNT_OUT_W'(count);
      top_valid       <= (count != '0);
      top_value       <= (count != '0) ? top : '0;
    end
  end

endmodule

FILE: hw/rtl/binary_heap_priority_queue_core.sv
// top level of the binary heap priority queue
// Priority queue of signed 32-bit words kept as a binary heap in a CAPACITY-deep
// ram, ordered smallest-first when min_order is 1 and largest-first when 0. One
// word is worked on at a time and each gives exactly one result word. Peek and
// clear go from decode straight to the response step, as does a rejected insert
// or extract, or an extract of the only entry. Insert lets the new word rise one
// level per step until it stops or reaches the root; extract moves the last entry
// to the root and lets it sink one level per step. The next word is taken in the
// cycle after the result is loaded. Each level step is a registered ram read
// followed by the compare and write back. A new word is taken while the previous
// result still waits in the output register; it then holds in its last step
// until the output register is free. Changing min_order does not reorder the
// stored entries; clear after changing it.
module binary_heap_priority_queue_core
  import hbpq_pkg::*;
#(
  parameter int CAP = CAPACITY
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write_en,
  input  logic                      cfg_write_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [FUNC_W-1:0]         func,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [STATUS_W-1:0]       status,
  output logic signed [VALUE_W-1:0] extracted_value,
  output logic [COUNT_OUT_W-1:0]    entry_count,
  output logic signed [VALUE_W-1:0] top_value,
  output logic                      top_valid
);

  hbpq_cmd_t  cmd;
  hbpq_stat_t stat;

  hbpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hbpq_dp #(
    .CAP (CAP)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data),
    .func            (func),
    .value           (value),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .extracted_value (extracted_value),
    .entry_count     (entry_count),
    .top_value       (top_value),
    .top_valid       (top_valid)
  );

endmodule
